/* design/glyph_row_blitter_top_defines.svh */
// Assertion macros shared by the glyph row blitter RTL.
// Used by grb_queue and grb_back; expects clk and rst_n in scope.
`ifndef GLYPH_ROW_BLITTER_TOP_DEFINES_SVH
`define GLYPH_ROW_BLITTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check a condition at every clock edge out of reset
`define GRB_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("%m: check failed");
// Check that a trigger implies a consequence
`define GRB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("%m: implication failed");
`else
`define GRB_ASSERT(label, cond)
`define GRB_ASSERT_IMPL(label, ante, cons)
`endif

`endif

/* design/grb_pkg.sv */
// Shared types, constants and pixel formatting for the glyph row blitter.
// No dependencies; imported by every module of the block.
package grb_pkg;

  // Screen limits and font geometry
  localparam int MAX_WIDTH       = 2048;
  localparam int MAX_HEIGHT      = 2048;
  localparam int GLYPH_COUNT_DEF = 256;
  localparam int GLYPH_ROWS      = 16;
  localparam int ROW_W           = 4;
  localparam int QUEUE_DEPTH     = 4;

  // Port widths
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 288;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BG     = 2'd3;

  // Register reset values
  localparam logic [11:0] RST_WIDTH  = 12'd640;
  localparam logic [11:0] RST_HEIGHT = 12'd480;
  localparam logic [5:0]  RST_DEPTH  = 6'd32;
  localparam logic [31:0] RST_BG     = 32'h00FF_FFFF;

  // Supported depths
  localparam logic [5:0] DEPTH_8  = 6'd8;
  localparam logic [5:0] DEPTH_16 = 6'd16;
  localparam logic [5:0] DEPTH_32 = 6'd32;

  // One classified item handed from front to back
  typedef struct packed {
    logic        is_draw;
    logic [7:0]  code;
    logic [3:0]  grow;
    logic [7:0]  bits;
    logic [4:0]  nrows;
    logic [7:0]  mask;
    logic [31:0] ink;
    logic [31:0] bg;
    logic [23:0] addr;
    logic [13:0] stride;
  } grb_entry_t;

  // Format a colour for the frame buffer depth
  function automatic logic [31:0] fmt_pixel(input logic [31:0] color,
                                            input logic [5:0] depth);
    logic [31:0] px;
    if (depth == DEPTH_8) begin
      px = {24'd0, color[7:0]};
    end else if (depth == DEPTH_16) begin
      px = {16'd0, color[23:19], color[15:10], color[7:3]};
    end else begin
      px = color;
    end
    return px;
  endfunction

endpackage

/* design/grb_front.sv */
// Front end: configuration registers, input acceptance and classification.
// Depends on grb_pkg; feeds grb_queue with precomputed draw parameters.
module grb_front #(
  parameter int GLYPH_COUNT = grb_pkg::GLYPH_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [grb_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                            in_tuser,
  input  logic                            cfg_we,
  input  logic [grb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [grb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            full,
  output logic                            push,
  output grb_pkg::grb_entry_t             push_entry
);
  import grb_pkg::*;

  logic [11:0] width_r;
  logic [11:0] height_r;
  logic [5:0]  depth_r;
  logic [31:0] bg_r;

  logic [7:0]  in_code;
  logic [3:0]  in_grow;
  logic [7:0]  in_bits;
  logic [10:0] in_ox;
  logic [10:0] in_oy;
  logic [31:0] in_ink;
  logic [7:0]  code_wrap;
  logic [11:0] w_sat;
  logic [11:0] h_sat;
  logic        depth_ok;
  logic [1:0]  byte_shift;
  logic [13:0] stride;
  logic [24:0] y_prod;
  logic [12:0] x_off;
  logic [11:0] rows_left;
  logic [4:0]  nrows;
  logic [7:0]  col_mask;
  logic        on_screen;
  logic        accept;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      depth_r  <= RST_DEPTH;
      bg_r     <= RST_BG;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_wdata[11:0];
        REG_HEIGHT: height_r <= cfg_wdata[11:0];
        REG_DEPTH:  depth_r  <= cfg_wdata[5:0];
        REG_BG:     bg_r     <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  // Unpack input fields
  assign in_code = in_tdata[7:0];
  assign in_grow = in_tdata[11:8];
  assign in_bits = in_tdata[19:12];
  assign in_ox   = in_tdata[30:20];
  assign in_oy   = in_tdata[41:31];
  assign in_ink  = in_tdata[73:42];

  // Wrap glyph index into the font store
  assign code_wrap = (9'(in_code) >= 9'(GLYPH_COUNT)) ?
                     8'(9'(in_code) - 9'(GLYPH_COUNT)) : in_code;

  // Saturate screen size
  assign w_sat = (13'(width_r) > 13'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : width_r;
  assign h_sat = (13'(height_r) > 13'(MAX_HEIGHT)) ? 12'(MAX_HEIGHT) : height_r;

  // Decode depth into a byte shift
  assign depth_ok = (depth_r == DEPTH_8) || (depth_r == DEPTH_16) || (depth_r == DEPTH_32);
  always_comb begin
    priority if (depth_r == DEPTH_32) begin
      byte_shift = 2'd2;
    end else if (depth_r == DEPTH_16) begin
      byte_shift = 2'd1;
    end else begin
      byte_shift = 2'd0;
    end
  end

  // Start address of the first row
  assign stride = 14'(w_sat) << byte_shift;
  assign y_prod = 25'(in_oy) * 25'(stride);
  assign x_off  = 13'(in_ox) << byte_shift;

  // Visible rows and columns
  assign on_screen = (12'(in_ox) < w_sat) && (12'(in_oy) < h_sat);
  assign rows_left = h_sat - 12'(in_oy);
  assign nrows     = (rows_left >= 12'd16) ? 5'd16 : rows_left[4:0];
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      col_mask[j] = (12'(in_ox) + 12'(j)) < w_sat;
    end
  end

  // Accept whenever the queue has room; drop draws that emit nothing
  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;
  assign push      = accept && ((in_tuser == KIND_LOAD) || (on_screen && depth_ok));

  always_comb begin
    push_entry.is_draw = (in_tuser == KIND_DRAW);
    push_entry.code    = code_wrap;
    push_entry.grow    = in_grow;
    push_entry.bits    = in_bits;
    push_entry.nrows   = nrows;
    push_entry.mask    = col_mask;
    push_entry.ink     = fmt_pixel(in_ink, depth_r);
    push_entry.bg      = fmt_pixel(bg_r, depth_r);
    push_entry.addr    = y_prod[23:0] + 24'(x_off);
    push_entry.stride  = stride;
  end

endmodule

/* design/grb_queue.sv */
// Short queue decoupling the front end from the row emitter.
// Depends on grb_pkg for the entry type and depth.
`include "glyph_row_blitter_top_defines.svh"
module grb_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  grb_pkg::grb_entry_t push_entry,
  input  logic                pop,
  output logic                full,
  output logic                empty,
  output grb_pkg::grb_entry_t head
);
  import grb_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  grb_entry_t       slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `GRB_ASSERT(a_count_bound, count_r <= CNT_W'(QUEUE_DEPTH))
  `GRB_ASSERT_IMPL(a_no_overflow, push, !full)
  `GRB_ASSERT_IMPL(a_no_underflow, pop, !empty)
  `GRB_ASSERT_IMPL(a_count_step, push && !pop, ##1 count_r == $past(count_r) + 1'b1)

endmodule

/* design/grb_back.sv */
// Back end: font store, row read pipeline and registered result output.
// Depends on grb_pkg; takes classified items from grb_queue.
`include "glyph_row_blitter_top_defines.svh"
module grb_back #(
  parameter int GLYPH_COUNT = grb_pkg::GLYPH_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           empty,
  input  grb_pkg::grb_entry_t            head,
  output logic                           pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [grb_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast
);
  import grb_pkg::*;

  localparam int CODE_W      = $clog2(GLYPH_COUNT);
  localparam int ADDR_W      = CODE_W + ROW_W;
  localparam int STORE_WORDS = GLYPH_COUNT * GLYPH_ROWS;

  logic [7:0]  font_mem [STORE_WORDS];

  // Current draw
  logic        busy_r;
  grb_entry_t  cur_r;
  logic [4:0]  row_r;
  logic [23:0] addr_r;

  // Read stage
  logic        rd_valid_r;
  logic [7:0]  font_q_r;
  logic [23:0] rd_addr_r;
  logic        rd_last_r;
  logic [7:0]  rd_mask_r;
  logic [31:0] rd_ink_r;
  logic [31:0] rd_bg_r;

  // Output stage
  logic        out_valid_r;
  logic [23:0] out_addr_r;
  logic [31:0] out_pix_r [8];
  logic [7:0]  out_mask_r;
  logic        out_last_r;

  logic        load_wr;
  logic        move;
  logic        issue;
  logic        issue_last;
  logic [4:0]  row_inc;
  logic [ADDR_W-1:0] wr_index;
  logic [ADDR_W-1:0] rd_index;

  assign pop        = !busy_r && !empty;
  assign load_wr    = pop && !head.is_draw;
  assign move       = !out_valid_r || out_tready;
  assign issue      = busy_r && (!rd_valid_r || move);
  assign row_inc    = row_r + 5'd1;
  assign issue_last = (row_inc == cur_r.nrows);
  assign wr_index   = {head.code[CODE_W-1:0], head.grow};
  assign rd_index   = {cur_r.code[CODE_W-1:0], row_r[ROW_W-1:0]};

  // Font store: write on load, read one row per issue
  always_ff @(posedge clk) begin
    if (load_wr) begin
      font_mem[wr_index] <= head.bits;
    end
    if (issue) begin
      font_q_r <= font_mem[rd_index];
    end
  end

  // Draw sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (pop && head.is_draw) begin
      busy_r <= 1'b1;
    end else if (issue && issue_last) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.is_draw) begin
      cur_r  <= head;
      row_r  <= '0;
      addr_r <= head.addr;
    end else if (issue) begin
      row_r  <= row_inc;
      addr_r <= addr_r + 24'(cur_r.stride);
    end
  end

  // Read stage bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else if (issue) begin
      rd_valid_r <= 1'b1;
    end else if (move) begin
      rd_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_addr_r <= addr_r;
      rd_last_r <= issue_last;
      rd_mask_r <= cur_r.mask;
      rd_ink_r  <= cur_r.ink;
      rd_bg_r   <= cur_r.bg;
    end
  end

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= rd_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (move && rd_valid_r) begin
      out_addr_r <= rd_addr_r;
      out_mask_r <= rd_mask_r;
      out_last_r <= rd_last_r;
      for (int j = 0; j < 8; j++) begin
        if (!rd_mask_r[j]) begin
          out_pix_r[j] <= '0;
        end else if (font_q_r[7-j]) begin
          out_pix_r[j] <= rd_ink_r;
        end else begin
          out_pix_r[j] <= rd_bg_r;
        end
      end
    end
  end

  // Pack result
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  always_comb begin
    out_tdata[23:0] = out_addr_r;
    for (int j = 0; j < 8; j++) begin
      out_tdata[24 + 32*j +: 32] = out_pix_r[j];
    end
    out_tdata[287:280] = out_mask_r;
  end

  `GRB_ASSERT_IMPL(a_row_in_range, busy_r, row_r < cur_r.nrows)
  `GRB_ASSERT_IMPL(a_last_ends_draw, issue && issue_last, ##1 !busy_r)
  `GRB_ASSERT_IMPL(a_draw_rows, pop && head.is_draw, head.nrows != 5'd0 && head.nrows <= 5'd16)

endmodule

/* design/glyph_row_blitter_top.sv */
// Top level of the glyph row blitter: front end, item queue and row emitter.
// Depends on grb_pkg, grb_front, grb_queue and grb_back.
//
// Usage:
//   in_*  : items, tuser = kind (load a font row / draw a character).
//           Load items write one 8-bit row of the font store and emit nothing.
//           Draw items off screen or at an unsupported depth are dropped.
//   out_* : one result per visible glyph row, tlast on the final row.
//   cfg_* : register writes; the user makes them only while the block is idle.
//           The block itself has no check for this.
// A draw waits in the queue, is held as the current draw, and each row passes
// the row read and pixel formatting registers. One font row is read per cycle
// from the store's single read port unless the receiver stalls; a draw holds
// the back end until its last visible row (up to 16) is read. Input is taken
// while the four-entry queue has room, so the front takes items during a draw.
// Reset restores width 640, height 480, depth 32 and a white background and
// empties the pipeline; font rows are undefined until loaded.
// When the receiver stalls, the current result holds, the row reads stop and
// the queue fills; in_tready drops once it is full.
module glyph_row_blitter_top #(
  parameter int GLYPH_COUNT = grb_pkg::GLYPH_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // char_code[7:0], glyph_row[11:8], row_bits[19:12], origin_x[30:20],
  // origin_y[41:31], ink_color[73:42], zero fill [79:74]
  input  logic [grb_pkg::IN_DATA_W-1:0]   in_tdata,
  // kind
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // row_address[23:0], pixel_0..pixel_7 at [24+32j +: 32], column_mask[287:280]
  output logic [grb_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic [grb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [grb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import grb_pkg::*;

  logic       push;
  logic       pop;
  logic       full;
  logic       empty;
  grb_entry_t push_entry;
  grb_entry_t head;

  grb_front #(
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .full       (full),
    .push       (push),
    .push_entry (push_entry)
  );

  grb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .empty      (empty),
    .head       (head)
  );

  grb_back #(
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
